FILE: rtl/sorted_alarm_timer_queue_assert.svh
// Assertion macros shared by the sorted alarm timer queue RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define SAT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SAT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sat_pkg.sv
// Package for the sorted alarm timer queue: op and status codes,
// controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package sat_pkg;

    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;

    // table read address select
    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_INC,
        RD_IDX_DEC,
        RD_ZERO
    } rd_sel_t;

    // table write select
    typedef enum logic [1:0] {
        WR_NONE,
        WR_MOVE_IDX,   // entry[idx]   <= read data
        WR_NEW_K,      // entry[k]     <= offered alarm
        WR_MOVE_DOWN   // entry[idx-k] <= read data
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_CNT,
        IDX_K
    } idx_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_SUB_K
    } cnt_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_SINGLE,   // result of insert or remove
        EMIT_POP,      // one expired alarm of a tick
        EMIT_NODUE     // tick with nothing due
    } emit_sel_t;

    typedef struct packed {
        logic      latch;
        logic      scan_done;
        rd_sel_t   rd;
        wr_sel_t   wr;
        idx_sel_t  idx;
        cnt_sel_t  cnt;
        emit_sel_t emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       scan_stop;
        logic       idx_zero;
        logic       idx_lt_cnt;
        logic       idx_gt_k;
        logic       idx_inc_lt_cnt;
        logic       emit_last;
        logic       out_free;
    } stat_t;

endpackage

FILE: rtl/sorted_alarm_timer_queue.sv
// Sorted alarm timer queue, top level; uses sat_pkg, sat_controller, sat_datapath.
// Each item walks one single-port table in order: an insert scans to its place, then moves
// the later entries up, top first; a remove scans to its tag, then moves the later entries down;
// a tick scans its due prefix, emits each popped alarm as a result, then compacts the table.
// One item at a time; the next is taken once the controller returns to idle (a tick after compaction).
// Reset (rst_n, async, low) clears count, walk state and result valid; table is undefined.
`timescale 1ns / 1ps

module sorted_alarm_timer_queue #(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [TAG_BITS-1:0]           alarm_tag,
    input  logic [TIME_BITS-1:0]          deadline,
    input  logic [TIME_BITS-1:0]          now_time,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic                          none_due,
    output logic [TAG_BITS-1:0]           out_tag,
    output logic [TIME_BITS-1:0]          out_deadline,
    output logic [TIME_BITS-1:0]          earliest,
    output logic [$clog2(CAPACITY+1)-1:0] pending_count,
    output logic                          last
);

    // The table lives in the datapath as one memory of {tag, deadline},
    // kept sorted by deadline with ties in arrival order. The controller
    // walks it one entry per cycle to find a position, then shifts entries
    // with a read and a write per move.
    //
    // A tick first scans the due prefix (capped at the per-tick result
    // limit) so that the final head deadline and count are known, then
    // reads out each due entry as a result, then compacts the table.
    //
    // The result register frees the item side: a new item is accepted
    // while the last result still waits, and any state that would load a
    // result stalls until the register is free.

    sat_pkg::cmd_t  cmd;
    sat_pkg::stat_t stat;

    sat_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .stat     (stat),
        .cmd      (cmd)
    );

    sat_datapath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .alarm_tag     (alarm_tag),
        .deadline      (deadline),
        .now_time      (now_time),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .none_due      (none_due),
        .out_tag       (out_tag),
        .out_deadline  (out_deadline),
        .earliest      (earliest),
        .pending_count (pending_count),
        .last          (last)
    );

endmodule

FILE: rtl/sat_datapath.sv
// Datapath of the alarm queue: sorted table memory, walk index, count,
// latched item and result register. Depends on sat_pkg and the assert header.
`timescale 1ns / 1ps

`include "sorted_alarm_timer_queue_assert.svh"

module sat_datapath #(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [1:0]                         op,
    input  logic [TAG_BITS-1:0]                alarm_tag,
    input  logic [TIME_BITS-1:0]               deadline,
    input  logic [TIME_BITS-1:0]               now_time,
    input  sat_pkg::cmd_t                      cmd,
    output sat_pkg::stat_t                     stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         status,
    output logic                               none_due,
    output logic [TAG_BITS-1:0]                out_tag,
    output logic [TIME_BITS-1:0]               out_deadline,
    output logic [TIME_BITS-1:0]               earliest,
    output logic [$clog2(CAPACITY+1)-1:0]      pending_count,
    output logic                               last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = TAG_BITS + TIME_BITS;

    logic [EW-1:0] entry_mem [CAPACITY];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] k_reg;
    logic [CW:0]   idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] idx_down;

    logic [1:0]           op_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [TIME_BITS-1:0] dl_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 full_reg;
    logic                 found_reg;
    logic [TIME_BITS-1:0] hit_dl_reg;
    logic [TIME_BITS-1:0] earliest_reg;

    logic [TAG_BITS-1:0]  rd_tag;
    logic [TIME_BITS-1:0] rd_dl;
    logic                 at_end;
    logic                 out_free;

    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    logic                 none_due_reg;
    logic [TAG_BITS-1:0]  out_tag_reg;
    logic [TIME_BITS-1:0] out_deadline_reg;
    logic [TIME_BITS-1:0] earliest_out_reg;
    logic [CW-1:0]        pending_reg;
    logic                 last_reg;

    assign rd_tag   = rd_data_reg[EW-1:TIME_BITS];
    assign rd_dl    = rd_data_reg[TIME_BITS-1:0];
    assign idx_inc  = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_down = idx_reg - k_reg;
    assign at_end   = (idx_reg == cnt_reg);
    assign out_free = !out_valid_reg || out_ready;

    // table port addressing
    always_comb
    begin
        rd_en = (cmd.rd != sat_pkg::RD_NONE);
        case (cmd.rd)
            sat_pkg::RD_IDX:     rd_addr = idx_reg[AW-1:0];
            sat_pkg::RD_IDX_INC: rd_addr = idx_inc[AW-1:0];
            sat_pkg::RD_IDX_DEC: rd_addr = idx_dec[AW-1:0];
            default:             rd_addr = '0;
        endcase
        wr_en   = (cmd.wr != sat_pkg::WR_NONE);
        wr_data = rd_data_reg;
        case (cmd.wr)
            sat_pkg::WR_MOVE_IDX:  wr_addr = idx_reg[AW-1:0];
            sat_pkg::WR_NEW_K:
            begin
                wr_addr = k_reg[AW-1:0];
                wr_data = {tag_reg, dl_reg};
            end
            sat_pkg::WR_MOVE_DOWN: wr_addr = idx_down[AW-1:0];
            default:               wr_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // status to the controller
    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = (cnt_reg == CW'(CAPACITY));
        stat.idx_zero  = (idx_reg == '0);
        stat.idx_lt_cnt     = (idx_reg < cnt_reg);
        stat.idx_gt_k       = (idx_reg > k_reg);
        stat.idx_inc_lt_cnt = (idx_inc < {1'b0, cnt_reg});
        stat.emit_last      = (idx_inc == {1'b0, k_reg});
        stat.out_free       = out_free;
        case (op_reg)
            sat_pkg::OP_INSERT: stat.scan_stop = at_end || (rd_dl > dl_reg);
            sat_pkg::OP_REMOVE: stat.scan_stop = at_end || (rd_tag == tag_reg);
            default:
                stat.scan_stop = at_end || (rd_dl > now_reg)
                              || (int'(idx_reg) == sat_pkg::MAX_RESULTS);
        endcase
    end

    always_comb
    begin
        case (cmd.cnt)
            sat_pkg::CNT_INC:   cnt_next = cnt_reg + CW'(1);
            sat_pkg::CNT_DEC:   cnt_next = cnt_reg - CW'(1);
            sat_pkg::CNT_SUB_K: cnt_next = cnt_reg - k_reg;
            default:            cnt_next = cnt_reg;
        endcase
        case (cmd.idx)
            sat_pkg::IDX_ZERO: idx_next = '0;
            sat_pkg::IDX_INC:  idx_next = idx_inc[CW-1:0];
            sat_pkg::IDX_DEC:  idx_next = idx_dec;
            sat_pkg::IDX_CNT:  idx_next = cnt_reg;
            sat_pkg::IDX_K:    idx_next = k_reg;
            default:           idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.scan_done)
            begin
                k_reg <= idx_reg;
            end
            if (cmd.emit != sat_pkg::EMIT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // latched item, walk results and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op;
            tag_reg  <= alarm_tag;
            dl_reg   <= deadline;
            now_reg  <= now_time;
            full_reg <= (cnt_reg == CW'(CAPACITY));
        end
        if (cmd.scan_done)
        begin
            found_reg    <= (idx_reg < cnt_reg);
            hit_dl_reg   <= rd_dl;
            earliest_reg <= (idx_reg < cnt_reg) ? rd_dl : {TIME_BITS{1'b1}};
        end
        case (cmd.emit)
            sat_pkg::EMIT_SINGLE:
            begin
                none_due_reg     <= 1'b0;
                out_tag_reg      <= tag_reg;
                earliest_out_reg <= (cnt_reg != '0) ? rd_dl : {TIME_BITS{1'b1}};
                pending_reg      <= cnt_reg;
                last_reg         <= 1'b1;
                if (op_reg == sat_pkg::OP_INSERT)
                begin
                    status_reg       <= full_reg ? sat_pkg::ST_FULL : sat_pkg::ST_INSERTED;
                    out_deadline_reg <= dl_reg;
                end
                else
                begin
                    status_reg       <= found_reg ? sat_pkg::ST_REMOVED
                                                  : sat_pkg::ST_NOT_FOUND;
                    out_deadline_reg <= found_reg ? hit_dl_reg : '0;
                end
            end
            sat_pkg::EMIT_POP:
            begin
                status_reg       <= sat_pkg::ST_EXPIRED;
                none_due_reg     <= 1'b0;
                out_tag_reg      <= rd_tag;
                out_deadline_reg <= rd_dl;
                earliest_out_reg <= earliest_reg;
                pending_reg      <= cnt_reg - k_reg;
                last_reg         <= stat.emit_last;
            end
            sat_pkg::EMIT_NODUE:
            begin
                status_reg       <= sat_pkg::ST_EXPIRED;
                none_due_reg     <= 1'b1;
                out_tag_reg      <= '0;
                out_deadline_reg <= '0;
                earliest_out_reg <= earliest_reg;
                pending_reg      <= cnt_reg;
                last_reg         <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign none_due      = none_due_reg;
    assign out_tag       = out_tag_reg;
    assign out_deadline  = out_deadline_reg;
    assign earliest      = earliest_out_reg;
    assign pending_count = pending_reg;
    assign last          = last_reg;

    `SAT_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(CAPACITY), "entry count above capacity")
    `SAT_ASSERT_ALWAYS(a_idx_bound, idx_reg <= cnt_reg, "walk index beyond entry count")
    `SAT_ASSERT_IMPLIES(a_emit_free, cmd.emit != sat_pkg::EMIT_NONE, out_free,
        "result loaded over an untaken result")
    `SAT_ASSERT_IMPLIES(a_no_overfill, cmd.cnt == sat_pkg::CNT_INC,
        cnt_reg < CW'(CAPACITY), "insert into a full table")

endmodule

FILE: rtl/sat_controller.sv
// Sequencer of the alarm queue: walks the table for insert, remove and tick.
// Depends on sat_pkg; drives sat_datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module sat_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     op,
    input  sat_pkg::stat_t stat,
    output sat_pkg::cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_SCAN    = 13'b0000000000010,
        S_I_CHK   = 13'b0000000000100,
        S_I_WR    = 13'b0000000001000,
        S_R_CHK   = 13'b0000000010000,
        S_R_WR    = 13'b0000000100000,
        S_HEAD_RD = 13'b0000001000000,
        S_EMIT    = 13'b0000010000000,
        S_T_NONE  = 13'b0000100000000,
        S_T_ERD   = 13'b0001000000000,
        S_T_EMIT  = 13'b0010000000000,
        S_T_CRD   = 13'b0100000000000,
        S_T_CWR   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.latch     = 1'b0;
        cmd.scan_done = 1'b0;
        cmd.rd        = sat_pkg::RD_NONE;
        cmd.wr        = sat_pkg::WR_NONE;
        cmd.idx       = sat_pkg::IDX_HOLD;
        cmd.cnt       = sat_pkg::CNT_HOLD;
        cmd.emit      = sat_pkg::EMIT_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    cmd.rd    = sat_pkg::RD_ZERO;
                    cmd.idx   = sat_pkg::IDX_ZERO;
                    case (op)
                        sat_pkg::OP_INSERT: state_next = stat.full ? S_HEAD_RD : S_SCAN;
                        sat_pkg::OP_REMOVE: state_next = S_SCAN;
                        sat_pkg::OP_TICK:   state_next = S_SCAN;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!stat.scan_stop)
                begin
                    cmd.rd  = sat_pkg::RD_IDX_INC;
                    cmd.idx = sat_pkg::IDX_INC;
                end
                else
                begin
                    cmd.scan_done = 1'b1;
                    case (stat.op)
                        sat_pkg::OP_INSERT:
                        begin
                            cmd.idx    = sat_pkg::IDX_CNT;
                            state_next = S_I_CHK;
                        end
                        sat_pkg::OP_REMOVE:
                            state_next = stat.idx_lt_cnt ? S_R_CHK : S_HEAD_RD;
                        default:
                        begin
                            cmd.idx    = sat_pkg::IDX_ZERO;
                            state_next = stat.idx_zero ? S_T_NONE : S_T_ERD;
                        end
                    endcase
                end
            end
            // open a gap at the insert position, top entry first
            S_I_CHK:
            begin
                if (stat.idx_gt_k)
                begin
                    cmd.rd     = sat_pkg::RD_IDX_DEC;
                    state_next = S_I_WR;
                end
                else
                begin
                    cmd.wr     = sat_pkg::WR_NEW_K;
                    cmd.cnt    = sat_pkg::CNT_INC;
                    state_next = S_HEAD_RD;
                end
            end
            S_I_WR:
            begin
                cmd.wr     = sat_pkg::WR_MOVE_IDX;
                cmd.idx    = sat_pkg::IDX_DEC;
                state_next = S_I_CHK;
            end
            // close the hole left by the removed entry
            S_R_CHK:
            begin
                if (stat.idx_inc_lt_cnt)
                begin
                    cmd.rd     = sat_pkg::RD_IDX_INC;
                    state_next = S_R_WR;
                end
                else
                begin
                    cmd.cnt    = sat_pkg::CNT_DEC;
                    state_next = S_HEAD_RD;
                end
            end
            S_R_WR:
            begin
                cmd.wr     = sat_pkg::WR_MOVE_IDX;
                cmd.idx    = sat_pkg::IDX_INC;
                state_next = S_R_CHK;
            end
            S_HEAD_RD:
            begin
                cmd.rd     = sat_pkg::RD_ZERO;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = sat_pkg::EMIT_SINGLE;
                    state_next = S_IDLE;
                end
            end
            S_T_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = sat_pkg::EMIT_NODUE;
                    state_next = S_IDLE;
                end
            end
            S_T_ERD:
            begin
                cmd.rd     = sat_pkg::RD_IDX;
                state_next = S_T_EMIT;
            end
            S_T_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = sat_pkg::EMIT_POP;
                    if (stat.emit_last)
                    begin
                        cmd.idx    = sat_pkg::IDX_K;
                        state_next = S_T_CRD;
                    end
                    else
                    begin
                        cmd.idx    = sat_pkg::IDX_INC;
                        state_next = S_T_ERD;
                    end
                end
            end
            // slide the survivors down over the popped head entries
            S_T_CRD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.rd     = sat_pkg::RD_IDX;
                    state_next = S_T_CWR;
                end
                else
                begin
                    cmd.cnt    = sat_pkg::CNT_SUB_K;
                    cmd.idx    = sat_pkg::IDX_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_T_CWR:
            begin
                cmd.wr     = sat_pkg::WR_MOVE_DOWN;
                cmd.idx    = sat_pkg::IDX_INC;
                state_next = S_T_CRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sim/sat_result_checker.sv
// Result checker for the sorted alarm timer queue: watches both channels,
// keeps its own sorted alarm list and compares every result. Uses sat_pkg.
`timescale 1ns / 1ps

module sat_result_checker #(
    parameter int CAPACITY  = 16,
    parameter int TIME_BITS = 48,
    parameter int TAG_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [TAG_BITS-1:0]           alarm_tag,
    input  logic [TIME_BITS-1:0]          deadline,
    input  logic [TIME_BITS-1:0]          now_time,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    status,
    input  logic                          none_due,
    input  logic [TAG_BITS-1:0]           out_tag,
    input  logic [TIME_BITS-1:0]          out_deadline,
    input  logic [TIME_BITS-1:0]          earliest,
    input  logic [$clog2(CAPACITY+1)-1:0] pending_count,
    input  logic                          last,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [2:0]           status;
        logic                 none_due;
        logic [TAG_BITS-1:0]  tag;
        logic [TIME_BITS-1:0] dl;
        logic [TIME_BITS-1:0] earliest;
        logic [CNT_W-1:0]     count;
        logic                 last;
    } alarm_result_t;

    // own copy of the sorted alarm list
    logic [TIME_BITS-1:0] slot_dl  [CAPACITY];
    logic [TAG_BITS-1:0]  slot_tag [CAPACITY];
    int                   slot_count = 0;

    alarm_result_t due_results[$];
    int            bad_results = 0;

    assign mismatches = bad_results;

    function automatic string show_result(alarm_result_t r);
        return $sformatf("status=%0d none_due=%0b tag=%h dl=%h earliest=%h count=%0d last=%0b",
            r.status, r.none_due, r.tag, r.dl, r.earliest, r.count, r.last);
    endfunction

    task automatic drop_slot(input int idx);
        for (int j = idx; j + 1 < slot_count; j++)
        begin
            slot_dl[j]  = slot_dl[j + 1];
            slot_tag[j] = slot_tag[j + 1];
        end
        slot_count--;
    endtask

    // works out the results of one accepted item and queues them
    task automatic apply_alarm_op(input logic [1:0] o, input logic [TAG_BITS-1:0] t,
                                  input logic [TIME_BITS-1:0] d,
                                  input logic [TIME_BITS-1:0] now);
        alarm_result_t        fresh[$];
        alarm_result_t        r;
        int                   pos;
        logic [TIME_BITS-1:0] head;
        r = '0;
        case (o)
            sat_pkg::OP_INSERT:
            begin
                r.tag = t;
                r.dl  = d;
                if (slot_count >= CAPACITY)
                begin
                    r.status = sat_pkg::ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < slot_count && slot_dl[pos] <= d)
                        pos++;
                    for (int i = slot_count; i > pos; i--)
                    begin
                        slot_dl[i]  = slot_dl[i - 1];
                        slot_tag[i] = slot_tag[i - 1];
                    end
                    slot_dl[pos]  = d;
                    slot_tag[pos] = t;
                    slot_count++;
                    r.status = sat_pkg::ST_INSERTED;
                end
                fresh.push_back(r);
            end
            sat_pkg::OP_REMOVE:
            begin
                pos = 0;
                while (pos < slot_count && slot_tag[pos] != t)
                    pos++;
                r.tag = t;
                if (pos < slot_count)
                begin
                    r.status = sat_pkg::ST_REMOVED;
                    r.dl     = slot_dl[pos];
                    drop_slot(pos);
                end
                else
                begin
                    r.status = sat_pkg::ST_NOT_FOUND;
                end
                fresh.push_back(r);
            end
            sat_pkg::OP_TICK:
            begin
                r.status = sat_pkg::ST_EXPIRED;
                while (fresh.size() < sat_pkg::MAX_RESULTS && slot_count > 0
                       && slot_dl[0] <= now)
                begin
                    r.tag = slot_tag[0];
                    r.dl  = slot_dl[0];
                    fresh.push_back(r);
                    drop_slot(0);
                end
                if (fresh.size() == 0)
                begin
                    r.none_due = 1'b1;
                    fresh.push_back(r);
                end
            end
            default: ;  // unused op: no result
        endcase
        head = (slot_count != 0) ? slot_dl[0] : '1;
        foreach (fresh[k])
        begin
            fresh[k].earliest = head;
            fresh[k].count    = CNT_W'(slot_count);
            fresh[k].last     = (k == fresh.size() - 1);
            due_results.push_back(fresh[k]);
        end
    endtask

    always @(posedge clk)
    begin
        alarm_result_t got;
        alarm_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                apply_alarm_op(op, alarm_tag, deadline, now_time);
            if (out_valid && out_ready)
            begin
                got = '{status, none_due, out_tag, out_deadline, earliest, pending_count, last};
                if (due_results.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%t: unexpected result: %s", $realtime, show_result(got));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        bad_results++;
                        if (bad_results <= 10)
                        begin
                            $display("%t: result mismatch", $realtime);
                            $display("    expected %s", show_result(want));
                            $display("    actual   %s", show_result(got));
                        end
                    end
                end
            end
        end
        outstanding <= due_results.size();
    end

endmodule

FILE: sim/sorted_alarm_timer_queue_test.sv
// Testbench top for the sorted alarm timer queue: clock, reset, item stimulus
// and verdict. Depends on sat_pkg, sorted_alarm_timer_queue and sat_result_checker.
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_test;

    localparam int CAPACITY  = 16;
    localparam int TIME_BITS = 48;
    localparam int TAG_BITS  = 8;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // op code the block ignores; not named in the package
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 220;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int SETTLE       = 100;    // longest item is well under this
    localparam int CYCLE_LIMIT  = 400000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [1:0]           op        = '0;
    logic [TAG_BITS-1:0]  alarm_tag = '0;
    logic [TIME_BITS-1:0] deadline  = '0;
    logic [TIME_BITS-1:0] now_time  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           status;
    logic                 none_due;
    logic [TAG_BITS-1:0]  out_tag;
    logic [TIME_BITS-1:0] out_deadline;
    logic [TIME_BITS-1:0] earliest;
    logic [CNT_W-1:0]     pending_count;
    logic                 last;

    int mismatches;
    int outstanding;
    int cycles = 0;

    // stimulus-side controls, all written with nonblocking assignments
    bit calm      = 1'b0;  // no idling on either side
    bit hold_req  = 1'b0;  // ask the receiver for its long hold-off
    bit hold_done = 1'b0;
    int hold_left = 0;

    sorted_alarm_timer_queue #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .alarm_tag     (alarm_tag),
        .deadline      (deadline),
        .now_time      (now_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .none_due      (none_due),
        .out_tag       (out_tag),
        .out_deadline  (out_deadline),
        .earliest      (earliest),
        .pending_count (pending_count),
        .last          (last)
    );

    sat_result_checker #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) alarm_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .alarm_tag     (alarm_tag),
        .deadline      (deadline),
        .now_time      (now_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .none_due      (none_due),
        .out_tag       (out_tag),
        .out_deadline  (out_deadline),
        .earliest      (earliest),
        .pending_count (pending_count),
        .last          (last),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side. Normally idles about a tenth of the time; once asked, it
    // holds off for a long stretch so results back up and the block stalls its input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    function automatic logic [TIME_BITS-1:0] any_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_BITS-1:0];
    endfunction

    // Offers one item and returns at the edge where it is taken. Random idle
    // cycles go in front; valid is never dropped while an item is on offer.
    task automatic send_item(input logic [1:0] o, input logic [TAG_BITS-1:0] t,
                             input logic [TIME_BITS-1:0] d,
                             input logic [TIME_BITS-1:0] now);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        alarm_tag <= t;
        deadline  <= d;
        now_time  <= now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Sender stands still until every expected result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [TIME_BITS-1:0] time_base;
        logic [TIME_BITS-1:0] d;
        logic [TAG_BITS-1:0]  t;
        logic [TAG_BITS-1:0]  recent_tags[$];
        int                   sent;
        int                   kind;

        time_base = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // empty table: tick with nothing due, remove that misses
        send_item(sat_pkg::OP_TICK,   '0,    '0, '0);
        send_item(sat_pkg::OP_REMOVE, '1,    '0, '0);
        // extremes of tag and deadline, equal deadlines kept in arrival order
        send_item(sat_pkg::OP_INSERT, '0,    '0,         '0);
        send_item(sat_pkg::OP_INSERT, '1,    '1,         '0);
        send_item(sat_pkg::OP_INSERT, 8'h05, 48'd100,    '0);
        send_item(sat_pkg::OP_INSERT, 8'h06, 48'd100,    '0);
        send_item(sat_pkg::OP_REMOVE, 8'h06, '0,         '0);   // hit in the middle
        send_item(sat_pkg::OP_REMOVE, 8'h99, '0,         '0);   // tag not present
        send_item(OP_UNUSED,          '1,    '1,         '1);   // ignored, no result
        send_item(sat_pkg::OP_TICK,   '0,    '0,         48'd100);  // pops two
        // fill up (one entry left over), then an insert into a full table
        for (int i = 0; i < 15; i++)
            send_item(sat_pkg::OP_INSERT, TAG_BITS'(8'h10 + i),
                      TIME_BITS'(40 + (i % 4) * 10), '0);
        send_item(sat_pkg::OP_INSERT, 8'hA5, 48'd1,  '0);
        // everything due at once: sixteen results from one tick
        send_item(sat_pkg::OP_TICK,   '0,    '0,     '1);
        drain();

        // --- random part ---
        // Mostly a moving time base with deadlines a little ahead of it, so
        // ticks pop runs of alarms; a few wild values as noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 40)
                hold_req <= 1'b1;
            if (sent == 120)
                drain();
            calm <= (sent >= 150 && sent < 200);

            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                t = ($urandom_range(0, 1) != 0) ? TAG_BITS'($urandom_range(0, 15))
                                                 : TAG_BITS'($urandom);
                if ($urandom_range(0, 99) < 5)
                    d = any_time();
                else
                    d = time_base + TIME_BITS'($urandom_range(0, 300));
                recent_tags.push_back(t);
                if (recent_tags.size() > 24)
                    void'(recent_tags.pop_front());
                send_item(sat_pkg::OP_INSERT, t, d, any_time());
                sent++;
            end
            else if (kind < 65)
            begin
                if (recent_tags.size() != 0 && $urandom_range(0, 99) < 80)
                    t = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
                else
                    t = TAG_BITS'($urandom);
                send_item(sat_pkg::OP_REMOVE, t, any_time(), any_time());
                sent++;
            end
            else if (kind < 95)
            begin
                time_base = time_base + TIME_BITS'($urandom_range(0, 80));
                d = ($urandom_range(0, 99) < 5) ? any_time() : time_base;
                send_item(sat_pkg::OP_TICK, TAG_BITS'($urandom), any_time(), d);
                sent++;
            end
            else
            begin
                // ignored op; does not count as an item
                send_item(OP_UNUSED, TAG_BITS'($urandom), any_time(), any_time());
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
